FILE: rtl/core/arf_pkg.sv
// ----------------------------------------------------------------------------
// arf_pkg
// shared types and constants for the annular rotational force pipeline
// ----------------------------------------------------------------------------
package arf_pkg;

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_RADIUS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER_RADIUS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_CONSTANT = 2'd2;

  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 63;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               neg_a;
    logic               neg_b;
  } carry_t;

endpackage

FILE: rtl/core/annular_rotational_force.sv
// ----------------------------------------------------------------------------
// annular_rotational_force
// adds a tangential force c*(-y, x)/r to particles whose radius lies in a band
// ----------------------------------------------------------------------------
// One word enters and one result word leaves per clock once the pipeline is
// full and out_tready does not hold it. The stages are, in order: magnitudes,
// products, the squared radius, the two-bit-per-stage square root, the band
// compare, the one-bit-per-stage restoring divider (two dividers side by side)
// and the output register. The whole pipeline holds while a result waits on
// out_tready. Result force fields are saturated to the signed 32-bit range;
// out_tuser carries the in-band flag.
module annular_rotational_force #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [arf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [arf_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // particle_index, pos_x, pos_y, force_x_in, force_y_in, zero fill
  input  logic [((INDEX_BITS+128+7)/8)*8-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // index_out, force_x_out, force_y_out, zero fill
  output logic [((INDEX_BITS+64+7)/8)*8-1:0]       out_tdata,
  // in_band
  output logic                                     out_tuser
);

  localparam int unsigned OUT_W = ((INDEX_BITS + 64 + 7) / 8) * 8;
  localparam int unsigned SQ = arf_pkg::SQ_STEPS;
  localparam int unsigned DV = arf_pkg::DV_STEPS;

  logic               adv;
  logic [30:0]        inner_r;
  logic [30:0]        outer_r;
  logic signed [31:0] rotc_r;

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= '0;
      rotc_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        arf_pkg::CFG_INNER_RADIUS: inner_r <= cfg_wdata[30:0];
        arf_pkg::CFG_OUTER_RADIUS: outer_r <= cfg_wdata[30:0];
        arf_pkg::CFG_ROT_CONSTANT: rotc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input unpack
  logic [INDEX_BITS-1:0] in_idx;
  logic [31:0]           in_x, in_y;
  arf_pkg::carry_t       in_ck;
  logic [31:0]           c_u;

  assign in_idx = in_tdata[INDEX_BITS-1:0];
  assign in_x   = in_tdata[INDEX_BITS +: 32];
  assign in_y   = in_tdata[INDEX_BITS+32 +: 32];
  assign c_u    = rotc_r;
  assign in_ck.fx    = in_tdata[INDEX_BITS+64 +: 32];
  assign in_ck.fy    = in_tdata[INDEX_BITS+96 +: 32];
  assign in_ck.neg_a = rotc_r[31] ^ in_y[31];
  assign in_ck.neg_b = rotc_r[31] ^ in_x[31];

  // stage 1: magnitudes
  logic                  v1_r;
  logic [INDEX_BITS-1:0] idx1_r;
  arf_pkg::carry_t       ck1_r;
  logic [31:0]           mx_r, my_r, mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= in_idx;
      ck1_r  <= in_ck;
      mx_r   <= in_x[31] ? (~in_x + 32'd1) : in_x;
      my_r   <= in_y[31] ? (~in_y + 32'd1) : in_y;
      mc_r   <= c_u[31] ? (~c_u + 32'd1) : c_u;
    end
  end

  // stage 2: products
  logic                  v2_r;
  logic [INDEX_BITS-1:0] idx2_r;
  arf_pkg::carry_t       ck2_r;
  logic [63:0]           sqx_r, sqy_r, pa_full, pb_full;
  logic [62:0]           pa_r, pb_r;

  assign pa_full = {32'd0, mc_r} * {32'd0, my_r};
  assign pb_full = {32'd0, mc_r} * {32'd0, mx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx2_r <= idx1_r;
      ck2_r  <= ck1_r;
      sqx_r  <= {32'd0, mx_r} * {32'd0, mx_r};
      sqy_r  <= {32'd0, my_r} * {32'd0, my_r};
      pa_r   <= pa_full[62:0];
      pb_r   <= pb_full[62:0];
    end
  end

  // square root pipeline, stage 0 holds the squared radius
  logic                  sq_v_r    [0:SQ];
  logic [INDEX_BITS-1:0] sq_idx_r  [0:SQ];
  arf_pkg::carry_t       sq_ck_r   [0:SQ];
  logic [62:0]           sq_pa_r   [0:SQ];
  logic [62:0]           sq_pb_r   [0:SQ];
  logic [63:0]           sq_n_r    [0:SQ];
  logic [32:0]           sq_rem_r  [0:SQ];
  logic [31:0]           sq_root_r [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_idx_r[0]  <= idx2_r;
      sq_ck_r[0]   <= ck2_r;
      sq_pa_r[0]   <= pa_r;
      sq_pb_r[0]   <= pb_r;
      sq_n_r[0]    <= sqx_r + sqy_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    logic [34:0] t, trial;
    logic        ge;
    assign t     = {sq_rem_r[i], sq_n_r[i][63:62]};
    assign trial = {1'b0, sq_root_r[i], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_idx_r[i+1]  <= sq_idx_r[i];
        sq_ck_r[i+1]   <= sq_ck_r[i];
        sq_pa_r[i+1]   <= sq_pa_r[i];
        sq_pb_r[i+1]   <= sq_pb_r[i];
        sq_n_r[i+1]    <= {sq_n_r[i][61:0], 2'b00};
        sq_rem_r[i+1]  <= ge ? 33'(t - trial) : t[32:0];
        sq_root_r[i+1] <= {sq_root_r[i][30:0], ge};
      end
    end
  end

  // divider pipeline, stage 0 holds radius and band flag
  logic                  dv_v_r    [0:DV];
  logic [INDEX_BITS-1:0] dv_idx_r  [0:DV];
  arf_pkg::carry_t       dv_ck_r   [0:DV];
  logic                  dv_band_r [0:DV];
  logic [31:0]           dv_rad_r  [0:DV];
  logic [62:0]           dv_qa_r   [0:DV];
  logic [62:0]           dv_qb_r   [0:DV];
  logic [31:0]           dv_ra_r   [0:DV];
  logic [31:0]           dv_rb_r   [0:DV];

  logic [31:0] root;
  assign root = sq_root_r[SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_idx_r[0]  <= sq_idx_r[SQ];
      dv_ck_r[0]   <= sq_ck_r[SQ];
      dv_band_r[0] <= (root > {1'b0, inner_r}) && (root < {1'b0, outer_r});
      dv_rad_r[0]  <= root;
      dv_qa_r[0]   <= sq_pa_r[SQ];
      dv_qb_r[0]   <= sq_pb_r[SQ];
      dv_ra_r[0]   <= '0;
      dv_rb_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DV; j++) begin : g_div
    logic [32:0] ta, tb, dr;
    logic        ga, gb;
    assign ta = {dv_ra_r[j], dv_qa_r[j][62]};
    assign tb = {dv_rb_r[j], dv_qb_r[j][62]};
    assign dr = {1'b0, dv_rad_r[j]};
    assign ga = ta >= dr;
    assign gb = tb >= dr;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_idx_r[j+1]  <= dv_idx_r[j];
        dv_ck_r[j+1]   <= dv_ck_r[j];
        dv_band_r[j+1] <= dv_band_r[j];
        dv_rad_r[j+1]  <= dv_rad_r[j];
        dv_qa_r[j+1]   <= {dv_qa_r[j][61:0], ga};
        dv_qb_r[j+1]   <= {dv_qb_r[j][61:0], gb};
        dv_ra_r[j+1]   <= ga ? 32'(ta - dr) : ta[31:0];
        dv_rb_r[j+1]   <= gb ? 32'(tb - dr) : tb[31:0];
      end
    end
  end

  // update and saturate
  arf_pkg::carry_t    fin_ck;
  logic signed [63:0] term_a, term_b, sum_x, sum_y;
  logic [31:0]        sat_x, sat_y;

  assign fin_ck = dv_ck_r[DV];
  assign term_a = dv_ck_r[DV].neg_a ? -$signed({1'b0, dv_qa_r[DV]})
                                    :  $signed({1'b0, dv_qa_r[DV]});
  assign term_b = dv_ck_r[DV].neg_b ? -$signed({1'b0, dv_qb_r[DV]})
                                    :  $signed({1'b0, dv_qb_r[DV]});
  assign sum_x = dv_band_r[DV] ? (64'(fin_ck.fx) - term_a) : 64'(fin_ck.fx);
  assign sum_y = dv_band_r[DV] ? (64'(fin_ck.fy) + term_b) : 64'(fin_ck.fy);

  always_comb begin
    if (sum_x[63:31] == '0 || sum_x[63:31] == '1) begin
      sat_x = sum_x[31:0];
    end else begin
      sat_x = sum_x[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (sum_y[63:31] == '0 || sum_y[63:31] == '1) begin
      sat_y = sum_y[31:0];
    end else begin
      sat_y = sum_y[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  logic                  out_v_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic [31:0]           out_fx_r, out_fy_r;
  logic                  out_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= dv_idx_r[DV];
      out_fx_r   <= sat_x;
      out_fy_r   <= sat_y;
      out_band_r <= dv_band_r[DV];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({out_fy_r, out_fx_r, out_idx_r});
  assign out_tuser  = out_band_r;

  // checks
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_band_rad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[0] && dv_band_r[0] |-> dv_rad_r[0] != 32'd0)
    else $error("in-band word with zero radius");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule
